@@ design/truss_bar_stiffness_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion helpers for the truss bar stiffness block
// Clocked on clk and disabled during reset; each use names its own label.
// ----------------------------------------------------------------------------
`ifndef TRUSS_BAR_STIFFNESS_ASSERT_SVH
`define TRUSS_BAR_STIFFNESS_ASSERT_SVH

// Same-cycle implication.
`define TBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tbs_pkg.sv @@
// ----------------------------------------------------------------------------
// tbs_pkg
// Transaction types and fixed-point constants of the truss bar stiffness block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbs_pkg;

  // Fixed widths of the fields and of the fixed-point formats.
  localparam int FIELD_W   = 32;
  localparam int RES_W     = 64;
  localparam int EA_W      = 64;
  localparam int FRAC_W    = 32;
  // Shift that turns a coordinate difference into a Q1.32 direction cosine.
  localparam int UNIT_SH   = 48;
  // Quotient widths of the three kinds of division.
  localparam int UNIT_QW   = 33;
  localparam int G_QW      = 80;
  localparam int STRAIN_QW = 64;
  // Every divider has this many stages so that all quotients line up.
  localparam int DIV_DEPTH = 80;

  // One bar element.
  typedef struct packed {
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
    logic [FIELD_W-1:0]        young_modulus;
    logic [FIELD_W-1:0]        section_area;
  } tbs_in_t;

  // Stiffness and strain terms of one element.
  typedef struct packed {
    logic signed [RES_W-1:0] stiff_cc;
    logic signed [RES_W-1:0] stiff_cs;
    logic signed [RES_W-1:0] stiff_ss;
    logic signed [RES_W-1:0] strain_cos;
    logic signed [RES_W-1:0] strain_sin;
    logic [EA_W-1:0]         axial_rigidity;
    logic                    degenerate;
  } tbs_out_t;

endpackage

`default_nettype wire

@@ design/tbs_div.sv @@
// ----------------------------------------------------------------------------
// tbs_div
// Pipelined restoring divider: one quotient bit per stage for the first QW
// stages, a plain delay in the rest, DEPTH stages in all. The caller guarantees that num >> QW is below den.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_div #(
  parameter int NW    = 96,
  parameter int DW    = 49,
  parameter int QW    = 80,
  parameter int DEPTH = 80,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  // Per-stage partial remainder, divisor, and a word that holds the unused
  // dividend bits on the left and the quotient bits shifting in on the right.
  logic [DW-1:0] rem_r  [DEPTH];
  logic [DW-1:0] den_r  [DEPTH];
  logic [QW-1:0] low_r  [DEPTH];
  logic [SW-1:0] side_r [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic [DW-1:0] rem_cur;
    logic [DW-1:0] den_cur;
    logic [QW-1:0] low_cur;
    logic [SW-1:0] side_cur;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] low_nxt;

    // Stage input: the ports for the first stage, the previous register after.
    if (k == 0) begin : g_first
      assign rem_cur  = DW'(num[NW-1:QW]);
      assign den_cur  = den;
      assign low_cur  = num[QW-1:0];
      assign side_cur = side_in;
    end else begin : g_next
      assign rem_cur  = rem_r[k-1];
      assign den_cur  = den_r[k-1];
      assign low_cur  = low_r[k-1];
      assign side_cur = side_r[k-1];
    end

    // One trial subtraction, or a plain delay once all bits are done.
    if (k < QW) begin : g_step
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;
      assign trial   = {rem_cur, low_cur[QW-1]};
      assign diff    = trial - {1'b0, den_cur};
      assign ge      = trial >= {1'b0, den_cur};
      assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      assign low_nxt = {low_cur[QW-2:0], ge};
    end else begin : g_hold
      assign rem_nxt = rem_cur;
      assign low_nxt = low_cur;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_cur;
        low_r[k]  <= low_nxt;
        side_r[k] <= side_cur;
      end
    end
  end

  assign quot     = low_r[DEPTH-1];
  assign side_out = side_r[DEPTH-1];

endmodule

`default_nettype wire

@@ design/tbs_sqrt.sv @@
// ----------------------------------------------------------------------------
// tbs_sqrt
// Pipelined integer square root: one root bit per stage, RW stages.
// The result is the floor of the square root of x.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_sqrt #(
  parameter int RW = 49,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x,
  input  logic [SW-1:0]   side_in,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  logic [RW:0]     rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] xr_r   [RW];
  logic [SW-1:0]   side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW:0]     rem_cur;
    logic [RW-1:0]   root_cur;
    logic [2*RW-1:0] xr_cur;
    logic [SW-1:0]   side_cur;
    logic [RW+2:0]   shifted;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign xr_cur   = x;
      assign side_cur = side_in;
    end else begin : g_next
      assign rem_cur  = rem_r[k-1];
      assign root_cur = root_r[k-1];
      assign xr_cur   = xr_r[k-1];
      assign side_cur = side_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign shifted = {rem_cur, xr_cur[2*RW-1:2*RW-2]};
    assign trial   = {1'b0, root_cur, 2'b01};
    assign diff    = shifted - trial;
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[RW:0] : shifted[RW:0];
        root_r[k] <= {root_cur[RW-2:0], ge};
        xr_r[k]   <= {xr_cur[2*RW-3:0], 2'b00};
        side_r[k] <= side_cur;
      end
    end
  end

  assign root     = root_r[RW-1];
  assign side_out = side_r[RW-1];

endmodule

`default_nettype wire

@@ design/truss_bar_stiffness.sv @@
// ----------------------------------------------------------------------------
// truss_bar_stiffness
// Stiffness, strain-displacement and axial rigidity terms of a plane bar.
// ----------------------------------------------------------------------------
// The block takes one bar element per cycle while in_stall is low and returns
// one result per element, in order. Each element passes through the
// bit-per-stage square-root pipeline of RW stages, where
// RW = min(COORD_WIDTH, 33) + 17, and the 80-stage divider pipelines that
// follow it. A stall on the output while a result is valid holds the whole
// pipeline, which then stalls the input in the same cycle.
// A zero-length element raises degenerate and returns zeros elsewhere.
`default_nettype none

module truss_bar_stiffness #(
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tbs_pkg::tbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tbs_pkg::tbs_out_t out_data
);

  import tbs_pkg::*;
  `include "truss_bar_stiffness_assert.svh"

  // Effective signed coordinate width, difference magnitude and root widths.
  localparam int CE    = (COORD_WIDTH > FIELD_W) ? FIELD_W + 1 : COORD_WIDTH;
  localparam int MW    = CE;
  localparam int HW    = 2 * MW + 1;
  localparam int RW    = MW + 17;
  localparam int LAT   = RW + DIV_DEPTH + 9;
  localparam int GHW   = G_QW + UNIT_QW - FRAC_W;
  localparam int MAG_W = GHW + UNIT_QW - FRAC_W;
  localparam int OVF_SH = STRAIN_QW - UNIT_SH;
  localparam logic [RES_W-1:0] NEG_LIM = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic [RES_W-1:0] POS_LIM = ~NEG_LIM;

  typedef struct packed {
    logic [HW-1:0]   h;
    logic [MW-1:0]   ax;
    logic [MW-1:0]   ay;
    logic            nx;
    logic            ny;
    logic [EA_W-1:0] ea;
    logic            zero;
  } sq_side_t;

  typedef struct packed {
    logic [STRAIN_QW-1:0] qx;
    logic [STRAIN_QW-1:0] qy;
    logic                 ovfx;
    logic                 ovfy;
    logic                 nx;
    logic                 ny;
    logic                 kneg;
    logic                 zero;
    logic [EA_W-1:0]      ea;
  } tail_t;

  // Low COORD_WIDTH bits, read as signed; wider settings read the field as unsigned.
  function automatic logic [CE-1:0] coord_ext(input logic [FIELD_W-1:0] v);
    coord_ext = CE'({1'b0, v});
  endfunction

  // Applies the sign to a magnitude and clamps to the signed 64-bit range.
  function automatic logic [RES_W-1:0] sat_mag(input logic [MAG_W-1:0] mag,
                                               input logic neg);
    logic [RES_W-1:0] res;
    if (neg) begin
      if (mag > {{(MAG_W-RES_W){1'b0}}, NEG_LIM}) res = NEG_LIM;
      else res = -mag[RES_W-1:0];
    end else begin
      if (mag > {{(MAG_W-RES_W){1'b0}}, POS_LIM}) res = POS_LIM;
      else res = mag[RES_W-1:0];
    end
    return res;
  endfunction

  // Global advance: the pipeline moves unless a finished result is held.
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Input register.
  logic [CE-1:0]      sx_r, sy_r, ex_r, ey_r;
  logic [FIELD_W-1:0] ym_r, sa_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= coord_ext(in_data.start_x);
      sy_r <= coord_ext(in_data.start_y);
      ex_r <= coord_ext(in_data.end_x);
      ey_r <= coord_ext(in_data.end_y);
      ym_r <= in_data.young_modulus;
      sa_r <= in_data.section_area;
    end
  end

  // Coordinate differences, split into sign and magnitude.
  logic [CE:0]        dx_c, dy_c;
  logic [MW-1:0]      ax_r, ay_r;
  logic               nx_r, ny_r;
  logic [FIELD_W-1:0] ym2_r, sa2_r;

  assign dx_c = {ex_r[CE-1], ex_r} - {sx_r[CE-1], sx_r};
  assign dy_c = {ey_r[CE-1], ey_r} - {sy_r[CE-1], sy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= dx_c[CE] ? MW'(-dx_c) : dx_c[MW-1:0];
      ay_r  <= dy_c[CE] ? MW'(-dy_c) : dy_c[MW-1:0];
      nx_r  <= dx_c[CE];
      ny_r  <= dy_c[CE];
      ym2_r <= ym_r;
      sa2_r <= sa_r;
    end
  end

  // Squares of the differences and the axial rigidity.
  logic [2*MW-1:0] ax2_r, ay2_r;
  logic [EA_W-1:0] ea_r;
  logic [MW-1:0]   ax3_r, ay3_r;
  logic            nx3_r, ny3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r <= ax_r * ax_r;
      ay2_r <= ay_r * ay_r;
      ea_r  <= ym2_r * sa2_r;
      ax3_r <= ax_r;
      ay3_r <= ay_r;
      nx3_r <= nx_r;
      ny3_r <= ny_r;
    end
  end

  // Squared length and the zero-length flag.
  sq_side_t sq_in_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_in_r.h    <= {1'b0, ax2_r} + {1'b0, ay2_r};
      sq_in_r.ax   <= ax3_r;
      sq_in_r.ay   <= ay3_r;
      sq_in_r.nx   <= nx3_r;
      sq_in_r.ny   <= ny3_r;
      sq_in_r.ea   <= ea_r;
      sq_in_r.zero <= (ax3_r == '0) && (ay3_r == '0);
    end
  end

  // Length in Q.16: root of the squared length scaled by 2^32.
  logic [RW-1:0] lr;
  sq_side_t      sq_out;

  tbs_sqrt #(
    .RW (RW),
    .SW ($bits(sq_side_t))
  ) u_sqrt (
    .clk      (clk),
    .en       (en),
    .x        ({1'b0, sq_in_r.h, {FRAC_W{1'b0}}}),
    .side_in  (sq_in_r),
    .root     (lr),
    .side_out (sq_out)
  );

  // Strain quotients overflow 64 bits when the dividend's top part reaches h.
  logic ovfx_c, ovfy_c;

  assign ovfx_c = HW'(sq_out.ax >> OVF_SH) >= sq_out.h;
  assign ovfy_c = HW'(sq_out.ay >> OVF_SH) >= sq_out.h;

  // Five dividers of equal depth run side by side.
  logic [UNIT_QW-1:0]   cm_q, sm_q;
  logic [G_QW-1:0]      g_q;
  logic [STRAIN_QW-1:0] qx_q, qy_q;
  logic                 zero_q, kneg_q;
  logic [EA_W-1:0]      ea_q;
  logic [1:0]           sx_side, sy_side;

  tbs_div #(
    .NW (MW + UNIT_SH), .DW (RW), .QW (UNIT_QW), .DEPTH (DIV_DEPTH), .SW (1)
  ) u_div_cos (
    .clk (clk), .en (en),
    .num ({sq_out.ax, {UNIT_SH{1'b0}}}), .den (lr), .side_in (sq_out.zero),
    .quot (cm_q), .side_out (zero_q)
  );

  tbs_div #(
    .NW (MW + UNIT_SH), .DW (RW), .QW (UNIT_QW), .DEPTH (DIV_DEPTH), .SW (1)
  ) u_div_sin (
    .clk (clk), .en (en),
    .num ({sq_out.ay, {UNIT_SH{1'b0}}}), .den (lr), .side_in (sq_out.nx ^ sq_out.ny),
    .quot (sm_q), .side_out (kneg_q)
  );

  tbs_div #(
    .NW (EA_W + FRAC_W), .DW (RW), .QW (G_QW), .DEPTH (DIV_DEPTH), .SW (EA_W)
  ) u_div_rig (
    .clk (clk), .en (en),
    .num ({sq_out.ea, {FRAC_W{1'b0}}}), .den (lr), .side_in (sq_out.ea),
    .quot (g_q), .side_out (ea_q)
  );

  tbs_div #(
    .NW (MW + UNIT_SH + 1), .DW (HW), .QW (STRAIN_QW), .DEPTH (DIV_DEPTH), .SW (2)
  ) u_div_stx (
    .clk (clk), .en (en),
    .num ({1'b0, sq_out.ax, {UNIT_SH{1'b0}}}), .den (sq_out.h),
    .side_in ({ovfx_c, sq_out.nx}),
    .quot (qx_q), .side_out (sx_side)
  );

  tbs_div #(
    .NW (MW + UNIT_SH + 1), .DW (HW), .QW (STRAIN_QW), .DEPTH (DIV_DEPTH), .SW (2)
  ) u_div_sty (
    .clk (clk), .en (en),
    .num ({1'b0, sq_out.ay, {UNIT_SH{1'b0}}}), .den (sq_out.h),
    .side_in ({ovfy_c, sq_out.ny}),
    .quot (qy_q), .side_out (sy_side)
  );

  // Gather the terms that only ride along to the output.
  tail_t tail_q;

  always_comb begin
    tail_q.qx   = qx_q;
    tail_q.qy   = qy_q;
    tail_q.ovfx = sx_side[1];
    tail_q.nx   = sx_side[0];
    tail_q.ovfy = sy_side[1];
    tail_q.ny   = sy_side[0];
    tail_q.kneg = kneg_q;
    tail_q.zero = zero_q;
    tail_q.ea   = ea_q;
  end

  // First products: EA/L times each cosine, in two 32-bit slices and a 16-bit top slice of EA/L.
  logic [64:0]        pc0_r, pc1_r, ps0_r, ps1_r;
  logic [48:0]        pc2_r, ps2_r;
  logic [UNIT_QW-1:0] cm1_r, sm1_r;
  tail_t              tail1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pc0_r   <= g_q[31:0] * cm_q;
      pc1_r   <= g_q[63:32] * cm_q;
      pc2_r   <= g_q[79:64] * cm_q;
      ps0_r   <= g_q[31:0] * sm_q;
      ps1_r   <= g_q[63:32] * sm_q;
      ps2_r   <= g_q[79:64] * sm_q;
      cm1_r   <= cm_q;
      sm1_r   <= sm_q;
      tail1_r <= tail_q;
    end
  end

  // Recombine the slices and drop 32 fraction bits.
  logic [112:0]       gc_sum, gs_sum;
  logic [GHW-1:0]     gch_r, gsh_r;
  logic [UNIT_QW-1:0] cm2_r, sm2_r;
  tail_t              tail2_r;

  assign gc_sum = {48'b0, pc0_r} + {16'b0, pc1_r, 32'b0} + {pc2_r, 64'b0};
  assign gs_sum = {48'b0, ps0_r} + {16'b0, ps1_r, 32'b0} + {ps2_r, 64'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      gch_r   <= gc_sum[112:32];
      gsh_r   <= gs_sum[112:32];
      cm2_r   <= cm1_r;
      sm2_r   <= sm1_r;
      tail2_r <= tail1_r;
    end
  end

  // Second products for the three stiffness terms.
  logic [64:0] qcc0_r, qcc1_r, qcs0_r, qcs1_r, qss0_r, qss1_r;
  logic [49:0] qcc2_r, qcs2_r, qss2_r;
  tail_t       tail3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      qcc0_r  <= gch_r[31:0] * cm2_r;
      qcc1_r  <= gch_r[63:32] * cm2_r;
      qcc2_r  <= gch_r[80:64] * cm2_r;
      qcs0_r  <= gch_r[31:0] * sm2_r;
      qcs1_r  <= gch_r[63:32] * sm2_r;
      qcs2_r  <= gch_r[80:64] * sm2_r;
      qss0_r  <= gsh_r[31:0] * sm2_r;
      qss1_r  <= gsh_r[63:32] * sm2_r;
      qss2_r  <= gsh_r[80:64] * sm2_r;
      tail3_r <= tail2_r;
    end
  end

  // Recombine into the stiffness magnitudes.
  logic [113:0]     cc_sum, cs_sum, ss_sum;
  logic [MAG_W-1:0] mcc_r, mcs_r, mss_r;
  tail_t            tail4_r;

  assign cc_sum = {49'b0, qcc0_r} + {17'b0, qcc1_r, 32'b0} + {qcc2_r, 64'b0};
  assign cs_sum = {49'b0, qcs0_r} + {17'b0, qcs1_r, 32'b0} + {qcs2_r, 64'b0};
  assign ss_sum = {49'b0, qss0_r} + {17'b0, qss1_r, 32'b0} + {qss2_r, 64'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      mcc_r   <= cc_sum[113:32];
      mcs_r   <= cs_sum[113:32];
      mss_r   <= ss_sum[113:32];
      tail4_r <= tail3_r;
    end
  end

  // Signs, saturation and the zero-length case into the output register.
  tbs_out_t out_nxt;
  tbs_out_t out_r;

  always_comb begin
    out_nxt = '0;
    if (tail4_r.zero) begin
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.stiff_cc       = sat_mag(mcc_r, 1'b0);
      out_nxt.stiff_cs       = sat_mag(mcs_r, tail4_r.kneg);
      out_nxt.stiff_ss       = sat_mag(mss_r, 1'b0);
      out_nxt.strain_cos     = sat_mag(MAG_W'({tail4_r.ovfx, tail4_r.qx}), tail4_r.nx);
      out_nxt.strain_sin     = sat_mag(MAG_W'({tail4_r.ovfy, tail4_r.qy}), tail4_r.ny);
      out_nxt.axial_rigidity = tail4_r.ea;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // A degenerate element carries nothing but its flag.
  `TBS_ASSERT_IMP(a_degen_zero, out_valid && out_data.degenerate, out_data.stiff_cc == 0 && out_data.stiff_cs == 0 && out_data.stiff_ss == 0 && out_data.strain_cos == 0 && out_data.strain_sin == 0 && out_data.axial_rigidity == 0, "degenerate element with nonzero terms")

  // Diagonal stiffness terms are never negative.
  `TBS_ASSERT_IMP(a_diag_sign, out_valid && !out_data.degenerate, !out_data.stiff_cc[RES_W-1] && !out_data.stiff_ss[RES_W-1], "negative diagonal stiffness term")

  // A held pipeline keeps every valid bit in place.
  `TBS_ASSERT_NXT(a_hold_valid, !en, vld_r == $past(vld_r), "valid bits moved during a stall")

endmodule

`default_nettype wire

@@ verif/truss_bar_stiffness_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// truss_bar_stiffness_test
// Streams plane bar elements through the stiffness block and checks each
// returned transaction against a bit-exact fixed-point predictor. A short
// table of directed elements comes first, then random elements under
// several idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module truss_bar_stiffness_test;
  import tbs_pkg::*;

  localparam int RAND_PER_PHASE = 145;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 300;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tbs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b1;
  tbs_out_t out_data;

  // Expected terms, oldest first, and the error count.
  tbs_out_t bar_terms_q[$];
  int       mismatches = 0;
  int       accepted_bars = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_go = 1'b0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;

  // One directed row, with typed-in terms where they are obvious.
  typedef struct {
    tbs_in_t  bar;
    logic     typed;
    tbs_out_t terms;
  } bar_row_t;

  bar_row_t bar_table[$];

  truss_bar_stiffness u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Product chain ((g * a) >> 32) * b >> 32, kept to 128 bits.
  function automatic logic [127:0] scaled_triple(logic [127:0] g, logic [63:0] a,
                                                  logic [63:0] b);
    logic [127:0] p;
    p = g * {64'd0, a};
    p = p >> 32;
    p = p * {64'd0, b};
    return p >> 32;
  endfunction

  // Clamp a magnitude with its sign into the signed 64-bit range.
  function automatic logic [63:0] clamp_signed(logic [127:0] m, logic neg);
    logic [63:0] lim;
    lim = 64'd1 << 63;
    if (neg) begin
      if (m[127:64] != 0 || m[63:0] > lim) return lim;
      return -m[63:0];
    end
    if (m[127:64] != 0 || m[63:0] > lim - 1) return lim - 1;
    return m[63:0];
  endfunction

  // Direction cosine magnitude in Q1.32, never above one.
  function automatic logic [63:0] unit_cosine(logic [63:0] a, logic [63:0] len);
    logic [127:0] q;
    q = ({64'd0, a} << 48) / {64'd0, len};
    if (q > (128'd1 << 32)) return 64'd1 << 32;
    return q[63:0];
  endfunction

  // Stiffness, strain and rigidity terms of one bar element.
  function automatic tbs_out_t bar_terms(tbs_in_t b);
    logic signed [63:0] dx, dy;
    logic [63:0]        ax, ay, ea, len, t, cm, sm;
    logic [127:0]       h, hs, g;
    tbs_out_t           r;
    r  = '0;
    dx = {{32{b.end_x[31]}}, b.end_x} - {{32{b.start_x[31]}}, b.start_x};
    dy = {{32{b.end_y[31]}}, b.end_y} - {{32{b.start_y[31]}}, b.start_y};
    ax = dx[63] ? -dx : dx;
    ay = dy[63] ? -dy : dy;
    h  = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    if (h == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    ea  = {32'd0, b.young_modulus} * {32'd0, b.section_area};
    hs  = h << 32;
    len = '0;
    for (int i = 63; i >= 0; i--) begin
      t = len | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= hs) len = t;
    end
    cm = unit_cosine(ax, len);
    sm = unit_cosine(ay, len);
    g  = ({64'd0, ea} << 32) / {64'd0, len};
    r.stiff_cc       = clamp_signed(scaled_triple(g, cm, cm), 1'b0);
    r.stiff_cs       = clamp_signed(scaled_triple(g, cm, sm), dx[63] != dy[63]);
    r.stiff_ss       = clamp_signed(scaled_triple(g, sm, sm), 1'b0);
    r.strain_cos     = clamp_signed(({64'd0, ax} << 48) / h, dx[63]);
    r.strain_sin     = clamp_signed(({64'd0, ay} << 48) / h, dy[63]);
    r.axial_rigidity = ea;
    return r;
  endfunction

  // Random element: mostly realistic bars, some full-range and degenerate.
  function automatic tbs_in_t random_bar();
    tbs_in_t b;
    int      shape;
    shape     = $urandom_range(99);
    b.start_x = $urandom;
    b.start_y = $urandom;
    b.end_x   = $urandom;
    b.end_y   = $urandom;
    if (shape < 45) begin
      b.end_x = b.start_x + $signed($urandom_range(1 << 22)) - (1 << 21);
      b.end_y = b.start_y + $signed($urandom_range(1 << 22)) - (1 << 21);
    end else if (shape < 55) begin
      b.end_y = b.start_y;
    end else if (shape < 65) begin
      b.end_x = b.start_x;
    end else if (shape < 70) begin
      b.end_x = b.start_x + $signed($urandom_range(4)) - 2;
      b.end_y = b.start_y + $signed($urandom_range(4)) - 2;
    end else if (shape < 73) begin
      b.end_x = b.start_x;
      b.end_y = b.start_y;
    end
    b.young_modulus = $urandom;
    b.section_area  = $urandom;
    if ($urandom_range(1)) begin
      b.young_modulus = $urandom_range(32'h0100_0000);
      b.section_area  = $urandom_range(32'h0004_0000);
    end
    return b;
  endfunction

  function automatic bar_row_t make_row(logic [31:0] sx, logic [31:0] sy,
                                        logic [31:0] ex, logic [31:0] ey,
                                        logic [31:0] e, logic [31:0] a,
                                        logic typed);
    bar_row_t row;
    row.bar   = '{start_x: sx, start_y: sy, end_x: ex, end_y: ey,
                  young_modulus: e, section_area: a};
    row.typed = typed;
    row.terms = '0;
    row.terms.degenerate = typed;
    return row;
  endfunction

  // Record accepted elements and check returned transactions.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bar_terms_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", out_data);
      end else begin
        if (out_data !== bar_terms_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", bar_terms_q[0], out_data);
        end
        void'(bar_terms_q.pop_front());
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      accepted_bars <= accepted_bars + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one element and hold it until the block takes it.
  task automatic send_bar(tbs_in_t b, tbs_out_t terms);
    int target;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    bar_terms_q.push_back(terms);
    target = accepted_bars + 1;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    wait (accepted_bars == target);
  endtask

  initial begin
    bar_row_t row;
    tbs_in_t  b;
    // Directed rows: degenerate bars, unit axes, signs, extremes, saturation.
    bar_table.push_back(make_row(0, 0, 0, 0, '1, '1, 1'b1));
    bar_table.push_back(make_row(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                 32'h7fff_ffff, '1, '1, 1'b1));
    bar_table.push_back(make_row(0, 0, 32'h0001_0000, 0, 32'h0001_0000,
                                 32'h0001_0000, 1'b0));
    bar_table.push_back(make_row(0, 0, 0, 32'h0001_0000, 32'h0001_0000,
                                 32'h0001_0000, 1'b0));
    bar_table.push_back(make_row(0, 0, 32'hfffd_0000, 32'h0004_0000, 32'h00c8_0000,
                                 32'h0000_8000, 1'b0));
    bar_table.push_back(make_row(32'h0002_0000, 32'h0003_0000, 0, 0, 32'h1234_5678,
                                 32'h0000_0100, 1'b0));
    bar_table.push_back(make_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                 32'h7fff_ffff, '1, '1, 1'b0));
    bar_table.push_back(make_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                 32'h8000_0000, '1, '1, 1'b0));
    bar_table.push_back(make_row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000, '1, '1, 1'b0));
    bar_table.push_back(make_row(0, 0, 1, 0, '1, '1, 1'b0));
    bar_table.push_back(make_row(5, 5, 5, 4, '1, '1, 1'b0));
    bar_table.push_back(make_row(0, 0, 1, 32'hffff_ffff, '1, '1, 1'b0));
    bar_table.push_back(make_row(0, 0, 32'h0010_0000, 32'h0010_0000, 0, '1, 1'b0));
    bar_table.push_back(make_row(0, 0, 32'h0010_0000, 32'h0010_0000, '1, 0, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (bar_table[i]) begin
      row = bar_table[i];
      send_bar(row.bar, row.typed ? row.terms : bar_terms(row.bar));
    end

    // Random elements under three idling patterns, the hold-off in the last.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 82 : 0;
      recv_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 33 : 0;
      if (phase == 2) hold_go <= 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        b = random_bar();
        send_bar(b, bar_terms(b));
      end
    end
    in_valid <= 1'b0;

    while (bar_terms_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/tbs_pkg.sv
design/tbs_div.sv
design/tbs_sqrt.sv
design/truss_bar_stiffness.sv
verif/truss_bar_stiffness_test.sv
